// ===== src/erme_pkg.sv =====
`timescale 1ns / 1ps
package erme_pkg;

  localparam int RingDepth = 32;
  localparam int IdxW = $clog2(RingDepth);
  localparam int CntW = $clog2(RingDepth + 1);
  localparam int MedRank = RingDepth / 2;
  localparam logic [23:0] RateScale = 24'd16000000;
  localparam logic [25:0] TimeoutReset = 26'd3000000;

  localparam logic [1:0] ModeSync = 2'd0;
  localparam logic [1:0] ModeMotion = 2'd1;

  typedef struct packed {
    logic [1:0] mode;
    logic [63:0] timestamp_us;
    logic signed [31:0] motion_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] distance;
    logic [23:0] peak_rate;
    logic was_reset;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GAP_RD,
    ST_GAP_WAIT,
    ST_GAP_NEXT,
    ST_RANK_RD,
    ST_RANK_WAIT,
    ST_RANK_CMP,
    ST_DIV,
    ST_DONE,
    ST_OUT
  } state_t;

endpackage

// ===== src/erme_divider.sv =====
`timescale 1ns / 1ps
module erme_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [23:0] quotient
);
  import erme_pkg::*;

  logic [4:0]  count;
  logic [24:0] rem;
  logic [23:0] quo;
  logic [64:0] trial;
  logic [24:0] shifted;

  assign shifted = {rem[23:0], quo[23]};
  assign trial = {40'd0, shifted} - {1'b0, divisor};
  assign quotient = quo;

  // Restoring division, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= 5'd24;
      rem <= '0;
      quo <= RateScale;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[24:0];
        quo <= {quo[22:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[22:0], 1'b0};
      end
      count <= count - 5'd1;
      if (count == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider did not start");
  assert property (@(posedge clk) disable iff (rst) busy |-> count != 5'd0)
    else $error("divider count underflow");
  assert property (@(posedge clk) disable iff (rst) (busy && count == 5'd1) |=> !busy)
    else $error("divider overran");

endmodule

// ===== src/event_rate_median_estimator.sv =====
`timescale 1ns / 1ps
// Motion transfers are absorbed without leaving the idle state, and a sync
// transfer that leaves the ring unfilled offers its result in the cycle after
// it is accepted. Once the ring is full, a sync builds the gap list from the
// timestamp ring, stepping through read, wait and next states for each slot,
// then runs serial rank selection over the gaps, through one read port of the
// gap memory, then bit-serial division before the result is offered. The
// input is not ready again until the result has been taken. An idle sync
// clears the ring by resetting valid bits.
module event_rate_median_estimator (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  erme_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output erme_pkg::out_item_t  out_data,
  input  logic                 cfg_we,
  input  logic [25:0]          cfg_data
);
  import erme_pkg::*;

  state_t state, state_next;

  logic [25:0]        idle_timeout;
  logic [63:0]        ring [RingDepth];
  logic [RingDepth-1:0] ring_valid;
  logic [IdxW-1:0]    ring_pointer;
  logic               ring_filled;
  logic [63:0]        previous_time;
  logic signed [31:0] distance_sum;
  logic [23:0]        peak_rate_reg;
  logic               was_reset;

  logic [63:0]        gaps [RingDepth];
  logic [CntW-1:0]    gap_count;
  logic [CntW-1:0]    i_idx;
  logic [CntW-1:0]    j_idx;
  logic [63:0]        rd_a, rd_b;
  logic [63:0]        cand;
  logic [CntW-1:0]    less_cnt, leq_cnt;
  logic [63:0]        median;

  logic               div_start, div_busy;
  logic [23:0]        div_q;

  logic               accept;
  logic signed [32:0] msum;
  logic [63:0]        dt;
  logic               idle_gap;
  logic [IdxW-1:0]    ia, ib;
  logic [63:0]        va, vb;
  logic               gap_ok;

  assign accept = in_valid && in_ready;
  assign in_ready = (state == ST_IDLE);
  assign msum = {distance_sum[31], distance_sum} +
                {in_data.motion_value[31], in_data.motion_value};
  assign dt = in_data.timestamp_us - previous_time;
  assign idle_gap = (in_data.timestamp_us > previous_time) && (dt > {38'd0, idle_timeout});
  assign ia = i_idx[IdxW-1:0];
  assign ib = ia + 1'b1;
  assign va = ring_valid[ia] ? rd_a : 64'd0;
  assign vb = ring_valid[ib] ? rd_b : 64'd0;
  assign gap_ok = (va < vb) && (gap_count < CntW'(RingDepth - 1));

  erme_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .divisor(median),
    .busy(div_busy), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= TimeoutReset;
    end else if (cfg_we) begin
      idle_timeout <= cfg_data;
    end
  end

  // Ring and gap memories: one write, registered reads.
  always_ff @(posedge clk) begin
    if (accept && in_data.mode == ModeSync && !idle_gap) begin
      ring[ring_pointer] <= in_data.timestamp_us;
    end
    rd_a <= ring[ia];
    rd_b <= ring[ib];
    if (state == ST_GAP_NEXT && gap_ok) begin
      gaps[gap_count[IdxW-1:0]] <= vb - va;
    end
  end

  // The read address runs one gap index ahead of the comparison that uses it.
  logic [IdxW-1:0] gap_addr;
  always_comb begin
    if (state == ST_RANK_RD) gap_addr = i_idx[IdxW-1:0];
    else if (state == ST_RANK_CMP) gap_addr = j_idx[IdxW-1:0] + 1'b1;
    else gap_addr = '0;
  end

  logic [63:0] gap_rd;
  always_ff @(posedge clk) begin
    gap_rd <= gaps[gap_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ring_valid <= '0;
      ring_pointer <= '0;
      ring_filled <= 1'b0;
      previous_time <= '0;
      distance_sum <= '0;
      peak_rate_reg <= '0;
      was_reset <= 1'b0;
      gap_count <= '0;
      i_idx <= '0;
      j_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (accept && in_data.mode == ModeMotion) begin
            if (msum > 33'sd2147483647) distance_sum <= 32'sh7fffffff;
            else if (msum < -33'sd2147483648) distance_sum <= 32'sh80000000;
            else distance_sum <= msum[31:0];
          end else if (accept && in_data.mode == ModeSync) begin
            previous_time <= in_data.timestamp_us;
            was_reset <= idle_gap;
            i_idx <= '0;
            gap_count <= '0;
            if (idle_gap) begin
              distance_sum <= '0;
              peak_rate_reg <= '0;
              ring_valid <= '0;
              ring_pointer <= '0;
              ring_filled <= 1'b0;
            end else begin
              ring_valid[ring_pointer] <= 1'b1;
              ring_pointer <= ring_pointer + 1'b1;
              if (ring_pointer == IdxW'(RingDepth - 1)) ring_filled <= 1'b1;
            end
          end
        end
        ST_GAP_NEXT: begin
          if (gap_ok) begin
            gap_count <= gap_count + 1'b1;
          end
          i_idx <= i_idx + 1'b1;
          if (i_idx == CntW'(RingDepth - 1)) i_idx <= '0;
        end
        ST_RANK_WAIT: begin
          cand <= gap_rd;
          j_idx <= '0;
          less_cnt <= '0;
          leq_cnt <= '0;
        end
        ST_RANK_CMP: begin
          if (gap_rd < cand) less_cnt <= less_cnt + 1'b1;
          if (gap_rd <= cand) leq_cnt <= leq_cnt + 1'b1;
          j_idx <= j_idx + 1'b1;
          if (state_next == ST_RANK_RD) i_idx <= i_idx + 1'b1;
          if (state_next == ST_DIV) median <= cand;
        end
        ST_DONE: begin
          if (!div_busy && !div_start && div_q > peak_rate_reg) peak_rate_reg <= div_q;
        end
        default: ;
      endcase
      if (state_next == ST_OUT && state != ST_OUT) out_valid <= 1'b1;
      if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // Rank check uses the counts after the last comparison is folded in.
  logic [CntW-1:0] less_f, leq_f;
  assign less_f = less_cnt + CntW'(gap_rd < cand);
  assign leq_f = leq_cnt + CntW'(gap_rd <= cand);
  logic rank_hit;
  assign rank_hit = (less_f <= CntW'(MedRank)) && (leq_f > CntW'(MedRank));

  always_comb begin
    state_next = state;
    div_start = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_data.mode == ModeSync) begin
          if (!idle_gap && (ring_filled || ring_pointer == IdxW'(RingDepth - 1)))
            state_next = ST_GAP_RD;
          else
            state_next = ST_OUT;
        end
      end
      ST_GAP_RD: state_next = ST_GAP_WAIT;
      ST_GAP_WAIT: state_next = ST_GAP_NEXT;
      ST_GAP_NEXT: begin
        if (i_idx == CntW'(RingDepth - 1)) state_next = ST_RANK_RD;
        else state_next = ST_GAP_RD;
      end
      ST_RANK_RD: begin
        if (gap_count < CntW'(MedRank + 1) || i_idx >= gap_count) state_next = ST_OUT;
        else state_next = ST_RANK_WAIT;
      end
      ST_RANK_WAIT: state_next = ST_RANK_CMP;
      ST_RANK_CMP: begin
        if (j_idx + 1'b1 < gap_count) state_next = ST_RANK_CMP;
        else if (rank_hit) state_next = ST_DIV;
        else state_next = ST_RANK_RD;
      end
      ST_DIV: begin
        div_start = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: if (!div_busy) state_next = ST_OUT;
      ST_OUT: if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_data.distance = distance_sum;
  assign out_data.peak_rate = peak_rate_reg;
  assign out_data.was_reset = was_reset;

  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == ST_OUT)
    else $error("result shown outside output state");
  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("ready while a result waits");
  assert property (@(posedge clk) disable iff (rst) gap_count <= CntW'(RingDepth - 1))
    else $error("too many gaps");
  assert property (@(posedge clk) disable iff (rst) peak_rate_reg <= RateScale)
    else $error("peak rate out of range");

endmodule
